[sv/rational_arith_unit_assert.svh]
// Assertion macros shared by the rational arithmetic unit checkers.
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RAU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rational_arith_unit: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rational_arith_unit: next-cycle check failed");

`endif

[sv/rau_pkg.sv]
// Package with types and constants of the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

    // Field widths fixed by the interface
    localparam int OPC_W       = 2;
    localparam int RES_NUM_W   = 32;
    localparam int RES_DEN_W   = 30;
    localparam int STATUS_W    = 2;
    localparam int OUT_TDATA_W = ((RES_NUM_W + RES_DEN_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RES_NUM_W - RES_DEN_W;

    // Range limits of a reduced result
    localparam logic [32:0] NUM_POS_MAX = 33'h0_7FFF_FFFF;
    localparam logic [32:0] NUM_NEG_MAX = 33'h0_8000_0000;
    localparam logic [32:0] DEN_MAX     = 33'h0_3FFF_FFFF;

    typedef enum logic [OPC_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DEN_ZERO = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVF      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_ADD,
        S_ZCHK,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_CHECK,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

[sv/rational_arith_unit.sv]
// Top level: rational add, subtract, multiply and divide with GCD reduction.
// Operand errors skip from idle straight to the output state. Transactions are
// handled one at a time: s_tready is high only in idle, and the GCD loop and the
// bit-serial divider are used in sequence. One result can wait in the output
// register while the next transaction is taken.
// Reset: rst_n clears sequencer and valid flags asynchronously.
`timescale 1ns / 1ps
`default_nettype none

module rational_arith_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    // s_tdata: opcode, a_num, a_den, b_num, b_den (low to high), zero padded
    input  logic [((rau_pkg::OPC_W + 4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic s_tvalid,
    output logic s_tready,
    // m_tdata: res_num, res_den (low to high), zero padded
    output logic [rau_pkg::OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: status
    output logic [rau_pkg::STATUS_W-1:0]    m_tuser,
    output logic m_tvalid,
    input  logic m_tready
);

    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int NW = 2 * W + 1;
    localparam int CW = (NW > 33) ? NW : 33;

    state_t state_reg, state_next;

    // Unpacked input fields
    logic [OPC_W-1:0] in_op;
    logic [W-1:0]     in_an, in_ad, in_bn, in_bd;
    logic [W-1:0]     an_mag, ad_mag, bn_mag, bd_mag;
    logic             in_den_zero, in_div_zero, in_err;

    // Operand registers in sign-magnitude form
    logic [OPC_W-1:0] op_reg;
    logic [W-1:0]     an_m_reg, ad_m_reg, bn_m_reg, bd_m_reg;
    logic             an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;

    // Shared multiplier
    logic [W-1:0]     mul_x, mul_y;
    logic             mul_xs, mul_ys;
    logic [PW-1:0]    prod;
    logic             prod_s;

    // Products and raw fraction
    logic [PW-1:0]    t0_m_reg, t1_m_reg, den_m_reg;
    logic             t0_s_reg, t1_s_reg, den_s_reg;
    logic [NW-1:0]    num_m_reg;
    logic             num_s_reg;
    logic             neg_reg;
    logic [NW-1:0]    sum_m;
    logic             sum_s;

    // Reduced magnitudes
    logic [NW-1:0]    nm_reg, dm_reg;

    // Shared units
    logic             gcd_start, gcd_done;
    logic [NW-1:0]    gcd_g;
    logic             div_start, div_done;
    logic [NW-1:0]    div_a, div_q;

    // Final result and range check
    logic [CW-1:0]    nm_ext, dm_ext, res_ext;
    logic             ovf;
    logic [RES_NUM_W-1:0] rnum_reg, out_num_reg;
    logic [RES_DEN_W-1:0] rden_reg, out_den_reg;
    logic [STATUS_W-1:0]  rst_reg, out_st_reg;
    logic                 out_valid_reg;
    logic                 out_load;

    // Field unpacking and magnitudes
    assign in_op  = s_tdata[OPC_W-1:0];
    assign in_an  = s_tdata[OPC_W +: W];
    assign in_ad  = s_tdata[OPC_W + W +: W];
    assign in_bn  = s_tdata[OPC_W + 2 * W +: W];
    assign in_bd  = s_tdata[OPC_W + 3 * W +: W];
    assign an_mag = in_an[W-1] ? (~in_an + W'(1)) : in_an;
    assign ad_mag = in_ad[W-1] ? (~in_ad + W'(1)) : in_ad;
    assign bn_mag = in_bn[W-1] ? (~in_bn + W'(1)) : in_bn;
    assign bd_mag = in_bd[W-1] ? (~in_bd + W'(1)) : in_bd;

    // Early error checks on the incoming transaction
    assign in_den_zero = (in_ad == '0) || (in_bd == '0);
    assign in_div_zero = (in_op == OP_DIV) && (in_bn == '0);
    assign in_err      = in_den_zero || in_div_zero;

    // Multiplier and its product sign
    assign prod   = PW'(mul_x) * PW'(mul_y);
    assign prod_s = (prod != '0) && (mul_xs != mul_ys);

    // Sign-magnitude sum of the two cross products
    always_comb
    begin
        if (t0_s_reg == t1_s_reg)
        begin
            sum_m = NW'(t0_m_reg) + NW'(t1_m_reg);
            sum_s = t0_s_reg;
        end
        else if (t0_m_reg >= t1_m_reg)
        begin
            sum_m = NW'(t0_m_reg - t1_m_reg);
            sum_s = t0_s_reg;
        end
        else
        begin
            sum_m = NW'(t1_m_reg - t0_m_reg);
            sum_s = t1_s_reg;
        end
        if (sum_m == '0)
        begin
            sum_s = 1'b0;
        end
    end

    // Range check of the reduced fraction
    assign nm_ext  = CW'(nm_reg);
    assign dm_ext  = CW'(dm_reg);
    assign ovf     = (dm_ext > CW'(DEN_MAX)) ||
                     (neg_reg ? (nm_ext > CW'(NUM_NEG_MAX)) : (nm_ext > CW'(NUM_POS_MAX)));
    assign res_ext = neg_reg ? (CW'(0) - nm_ext) : nm_ext;

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = in_err ? S_OUT : S_MUL0;
                end
            end
            S_MUL0:
            begin
                state_next = ((op_reg == OP_ADD) || (op_reg == OP_SUB)) ? S_MUL1 : S_MUL2;
            end
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_ADD;
            S_ADD:   state_next = S_ZCHK;
            S_ZCHK:  state_next = (num_m_reg == '0) ? S_CHECK : S_GCD;
            S_GCD:
            begin
                if (gcd_done)
                begin
                    state_next = S_DIVN;
                end
            end
            S_DIVN:
            begin
                if (div_done)
                begin
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: state_next = S_OUT;
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, unit starts, multiplier operands
    always_comb
    begin
        s_tready  = (state_reg == S_IDLE);
        gcd_start = (state_reg == S_ZCHK) && (num_m_reg != '0);
        div_start = ((state_reg == S_GCD) && gcd_done) ||
                    ((state_reg == S_DIVN) && div_done);
        div_a     = (state_reg == S_GCD) ? num_m_reg : NW'(den_m_reg);
        mul_x     = an_m_reg;
        mul_xs    = an_s_reg;
        mul_y     = bd_m_reg;
        mul_ys    = bd_s_reg;
        unique case (state_reg)
            S_MUL0:
            begin
                if (op_reg == OP_MUL)
                begin
                    mul_y  = bn_m_reg;
                    mul_ys = bn_s_reg;
                end
            end
            S_MUL1:
            begin
                mul_x  = ad_m_reg;
                mul_xs = ad_s_reg;
                mul_y  = bn_m_reg;
                mul_ys = bn_s_reg;
            end
            S_MUL2:
            begin
                mul_x  = ad_m_reg;
                mul_xs = ad_s_reg;
                if (op_reg == OP_DIV)
                begin
                    mul_y  = bn_m_reg;
                    mul_ys = bn_s_reg;
                end
            end
            default:
            begin
                mul_x = an_m_reg;
            end
        endcase
    end

    // State register and output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, loaded per sequencer step
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_reg   <= in_op;
                    an_m_reg <= an_mag;
                    ad_m_reg <= ad_mag;
                    bn_m_reg <= bn_mag;
                    bd_m_reg <= bd_mag;
                    an_s_reg <= in_an[W-1];
                    ad_s_reg <= in_ad[W-1];
                    bd_s_reg <= in_bd[W-1];
                    // subtract: negate the second numerator unless it is zero
                    bn_s_reg <= ((in_op == OP_SUB) && (in_bn != '0)) ? ~in_bn[W-1]
                                                                     : in_bn[W-1];
                    rnum_reg <= '0;
                    rden_reg <= RES_DEN_W'(1);
                    rst_reg  <= in_den_zero ? ST_DEN_ZERO : ST_DIV_ZERO;
                end
            end
            S_MUL0:
            begin
                t0_m_reg <= prod;
                t0_s_reg <= prod_s;
                t1_m_reg <= '0;
                t1_s_reg <= 1'b0;
            end
            S_MUL1:
            begin
                t1_m_reg <= prod;
                t1_s_reg <= prod_s;
            end
            S_MUL2:
            begin
                den_m_reg <= prod;
                den_s_reg <= prod_s;
            end
            S_ADD:
            begin
                num_m_reg <= sum_m;
                num_s_reg <= sum_s;
                neg_reg   <= (sum_m != '0) && (sum_s != den_s_reg);
            end
            S_ZCHK:
            begin
                // zero numerator: no reduction
                nm_reg <= '0;
                dm_reg <= NW'(den_m_reg);
            end
            S_GCD:
            begin
                nm_reg <= nm_reg;
            end
            S_DIVN:
            begin
                if (div_done)
                begin
                    nm_reg <= div_q;
                end
            end
            S_DIVD:
            begin
                if (div_done)
                begin
                    dm_reg <= div_q;
                end
            end
            S_CHECK:
            begin
                if (ovf)
                begin
                    rnum_reg <= '0;
                    rden_reg <= RES_DEN_W'(1);
                    rst_reg  <= ST_OVF;
                end
                else
                begin
                    rnum_reg <= res_ext[RES_NUM_W-1:0];
                    rden_reg <= dm_ext[RES_DEN_W-1:0];
                    rst_reg  <= ST_OK;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_num_reg <= rnum_reg;
                    out_den_reg <= rden_reg;
                    out_st_reg  <= rst_reg;
                end
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

    // Shared GCD unit
    rau_gcd #(
        .N (NW)
    ) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .a     (num_m_reg),
        .b     (NW'(den_m_reg)),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    // Shared divider: numerator, then denominator, by the GCD
    rau_div #(
        .N (NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (gcd_g),
        .done     (div_done),
        .quotient (div_q)
    );

    // Output channel
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_den_reg, out_num_reg};
    assign m_tuser  = out_st_reg;
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

[sv/rau_gcd.sv]
// Binary GCD unit: one shift or subtract step per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rau_gcd #(
    parameter int N = 33
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] a,      // nonzero
    input  logic [N-1:0] b,      // nonzero
    output logic         done,
    output logic [N-1:0] g
);

    localparam int KW = $clog2(N + 1);

    logic [N-1:0]  u_reg;
    logic [N-1:0]  v_reg;
    logic [KW-1:0] k_reg;
    logic [N-1:0]  g_reg;
    logic          busy_reg;
    logic          done_reg;

    logic          u_ge_v;
    logic [N-1:0]  u_minus_v;
    logic [N-1:0]  v_minus_u;

    // Shared compare and subtract
    assign u_ge_v    = (u_reg >= v_reg);
    assign u_minus_v = u_reg - v_reg;
    assign v_minus_u = v_reg - u_reg;

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (u_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Working values: strip common twos, then reduce by odd differences
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            u_reg <= a;
            v_reg <= b;
            k_reg <= '0;
        end
        else if (busy_reg)
        begin
            priority if (u_reg == '0)
            begin
                g_reg <= v_reg << k_reg;
            end
            else if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + KW'(1);
            end
            else if (!u_reg[0])
            begin
                u_reg <= u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_reg <= v_reg >> 1;
            end
            else if (u_ge_v)
            begin
                u_reg <= u_minus_v >> 1;
            end
            else
            begin
                v_reg <= v_minus_u >> 1;
            end
        end
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule

`default_nettype wire

[sv/rau_div.sv]
// Restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rau_div #(
    parameter int N = 33
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [N-1:0] divisor,   // nonzero
    output logic         done,
    output logic [N-1:0] quotient
);

    localparam int CNTW = $clog2(N + 1);

    logic [N-1:0]    rem_reg;
    logic [N-1:0]    quo_reg;
    logic [N-1:0]    dvs_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [N:0]      trial;
    logic [N:0]      diff;
    logic            fits;

    // Trial subtract of the divisor from the shifted remainder
    assign trial = {rem_reg, quo_reg[N-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // Control and bit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[N-1:0] : trial[N-1:0];
            quo_reg <= {quo_reg[N-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[sv/rau_checker.sv]
// Port-level checker for the rational arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "rational_arith_unit_assert.svh"

module rau_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic [rau_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic [rau_pkg::STATUS_W-1:0]    m_tuser,
    input wire logic m_tvalid,
    input wire logic m_tready
);

    import rau_pkg::*;

    logic [RES_NUM_W-1:0] chk_num;
    logic [RES_DEN_W-1:0] chk_den;
    logic                 in_xact;
    logic                 stall;

    assign chk_num = m_tdata[RES_NUM_W-1:0];
    assign chk_den = m_tdata[RES_NUM_W +: RES_DEN_W];
    assign in_xact = s_tvalid && s_tready;
    assign stall   = m_tvalid && !m_tready;

    // A result held back keeps its valid and its payload
    `RAU_ASSERT_NEXT(a_out_hold, stall, m_tvalid)
    `RAU_ASSERT_NEXT(a_out_stable, stall, $stable(m_tdata) && $stable(m_tuser))

    // Only one transaction in work at a time
    `RAU_ASSERT_NEXT(a_busy_after_accept, in_xact, !s_tready)

    // Any error status comes with the result 0/1
    `RAU_ASSERT_SAME(a_err_result, m_tvalid && (m_tuser != ST_OK),
                     (chk_num == '0) && (chk_den == RES_DEN_W'(1)))

    // Denominator of a good result is never zero
    `RAU_ASSERT_SAME(a_den_nonzero, m_tvalid && (m_tuser == ST_OK), chk_den != '0)

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the rational arithmetic unit: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module tb_top;
    import rau_pkg::*;

    localparam int OPW        = 16;
    localparam int IN_W       = ((OPC_W + 4 * OPW + 7) / 8) * 8;
    localparam int RAND_ITEMS = 2000;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 400;

    typedef struct packed {
        logic [RES_NUM_W-1:0] num;
        logic [RES_DEN_W-1:0] den;
        status_t              status;
    } frac_result_t;

    logic                   clk;
    logic                   rst_n;
    logic [IN_W-1:0]        s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   m_tvalid;
    logic                   m_tready;

    logic [IN_W-1:0] pending_ops[$];
    frac_result_t    expected_fracs[$];
    int              errors;
    int              idle_cycles;
    bit              in_taken;
    bit              in_hold;
    bit              in_quiet;
    int              in_gap;
    bit              out_taken;
    bit              out_quiet;
    int              out_stall;

    rational_arith_unit #(
        .OPERAND_WIDTH(OPW)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    // Clock, 8 ns period
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Pack one operation into the input word, opcode lowest
    function automatic logic [IN_W-1:0] pack_op(opcode_t op, logic [OPW-1:0] an,
                                                logic [OPW-1:0] ad, logic [OPW-1:0] bn,
                                                logic [OPW-1:0] bd);
        logic [IN_W-1:0] w;
        w = '0;
        w[OPC_W-1:0] = op;
        w[OPC_W +: 4*OPW] = {bd, bn, ad, an};
        return w;
    endfunction

    // Exact fraction arithmetic with GCD reduction
    function automatic frac_result_t predict_fraction(logic [IN_W-1:0] w);
        opcode_t           op;
        longint            an, ad, bn, bd, num, den;
        longint unsigned   nm, dm, g, x, y, t;
        bit                neg;
        frac_result_t      r;
        op = opcode_t'(w[OPC_W-1:0]);
        an = longint'($signed(w[OPC_W +: OPW]));
        ad = longint'($signed(w[OPC_W + OPW +: OPW]));
        bn = longint'($signed(w[OPC_W + 2*OPW +: OPW]));
        bd = longint'($signed(w[OPC_W + 3*OPW +: OPW]));
        r.num = '0;
        r.den = RES_DEN_W'(1);
        r.status = ST_OK;
        // zero operand denominator wins over everything else
        if (ad == 0 || bd == 0) begin
            r.status = ST_DEN_ZERO;
            return r;
        end
        if (op == OP_DIV && bn == 0) begin
            r.status = ST_DIV_ZERO;
            return r;
        end
        if (op == OP_SUB)
            bn = -bn;
        case (op)
            OP_ADD, OP_SUB: begin
                num = an * bd + ad * bn;
                den = ad * bd;
            end
            OP_MUL: begin
                num = an * bn;
                den = ad * bd;
            end
            default: begin
                num = an * bd;
                den = ad * bn;
            end
        endcase
        // keep the denominator positive
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        neg = (num < 0);
        if (neg)
            nm = -num;
        else
            nm = num;
        dm = den;
        // zero numerator is left unreduced
        if (nm == 0) begin
            g = 1;
        end
        else begin
            x = nm;
            y = dm;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            g = x;
        end
        nm = nm / g;
        dm = dm / g;
        if (dm > DEN_MAX || nm > (neg ? NUM_NEG_MAX : NUM_POS_MAX)) begin
            r.status = ST_OVF;
            return r;
        end
        r.num = neg ? (32'd0 - nm[31:0]) : nm[31:0];
        r.den = dm[RES_DEN_W-1:0];
        return r;
    endfunction

    // Operand draw: full range, small values for reductions, and extremes
    function automatic logic [OPW-1:0] rand_operand(bit is_den);
        int              k;
        logic [OPW-1:0]  v;
        k = $urandom_range(0, 99);
        if (k < 40)
            v = OPW'($urandom);
        else if (k < 42)
            v = 16'h8000;
        else if (k < 50)
            case ($urandom_range(0, 4))
                0: v = 16'sd32767;
                1: v = -16'sd32767;
                2: v = 16'sd1;
                3: v = -16'sd1;
                default: v = 16'sd0;
            endcase
        else if (k < 85)
            v = 16'($signed($urandom_range(0, 40)) - 20);
        else
            v = 16'($signed($urandom_range(0, 510)) - 255);
        // zero denominators only now and then
        if (is_den && v == 0 && $urandom_range(0, 3) != 0)
            v = 16'sd1;
        return v;
    endfunction

    // Wait draw for one transaction, with runs of back-to-back traffic
    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 39) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    // Input driver, updates at the falling edge
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_taken) begin
                in_taken = 1'b0;
                in_hold  = 1'b0;
                in_gap   = draw_wait(in_quiet);
            end
            if (!in_hold) begin
                if (in_gap > 0) begin
                    in_gap--;
                end
                else if (pending_ops.size() > 0) begin
                    s_tdata <= pending_ops.pop_front();
                    in_hold = 1'b1;
                end
            end
            s_tvalid <= in_hold;
        end
    end

    // Result receiver back-pressure
    always @(negedge clk) begin
        if (rst_n) begin
            if (out_taken) begin
                out_taken = 1'b0;
                out_stall = draw_wait(out_quiet);
            end
            if (out_stall > 0) begin
                out_stall--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: predict on input transactions, check output transactions
    always @(posedge clk) begin
        frac_result_t exp_r;
        logic [RES_NUM_W-1:0] got_num;
        logic [RES_DEN_W-1:0] got_den;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                expected_fracs.push_back(predict_fraction(s_tdata));
                in_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                out_taken = 1'b1;
                got_num = m_tdata[RES_NUM_W-1:0];
                got_den = m_tdata[RES_NUM_W +: RES_DEN_W];
                if (expected_fracs.size() == 0) begin
                    $display("%0t: unexpected result num=%0d den=%0d status=%0d",
                             $time, $signed(got_num), got_den, m_tuser);
                    errors++;
                end
                else begin
                    exp_r = expected_fracs.pop_front();
                    if (got_num !== exp_r.num) begin
                        $display("%0t: res_num expected %0d actual %0d",
                                 $time, $signed(exp_r.num), $signed(got_num));
                        errors++;
                    end
                    if (got_den !== exp_r.den) begin
                        $display("%0t: res_den expected %0d actual %0d",
                                 $time, exp_r.den, got_den);
                        errors++;
                    end
                    if (m_tuser !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, m_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        errors      = 0;
        idle_cycles = 0;
        in_taken    = 1'b0;
        in_hold     = 1'b0;
        in_quiet    = 1'b0;
        in_gap      = 0;
        out_taken   = 1'b0;
        out_quiet   = 1'b0;
        out_stall   = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;

        // directed: extremes, each opcode, error and zero-numerator cases
        pending_ops.push_back(pack_op(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3));
        pending_ops.push_back(pack_op(OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd3));
        pending_ops.push_back(pack_op(OP_MUL, 16'sd2, 16'sd3, 16'sd3, 16'sd4));
        pending_ops.push_back(pack_op(OP_DIV, 16'sd2, 16'sd3, 16'sd4, 16'sd9));
        pending_ops.push_back(pack_op(OP_ADD, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767));
        pending_ops.push_back(pack_op(OP_SUB, -16'sd32767, 16'sd32766, 16'sd32767, -16'sd32765));
        pending_ops.push_back(pack_op(OP_MUL, -16'sd32767, 16'sd32766, 16'sd32767, 16'sd32765));
        pending_ops.push_back(pack_op(OP_DIV, 16'sd32767, -16'sd32767, -16'sd1, 16'sd32767));
        pending_ops.push_back(pack_op(OP_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1));
        pending_ops.push_back(pack_op(OP_DIV, 16'sd1, 16'sd1, 16'sd0, 16'sd0));
        pending_ops.push_back(pack_op(OP_MUL, 16'sd5, 16'sd7, 16'sd3, 16'sd0));
        pending_ops.push_back(pack_op(OP_DIV, 16'sd5, 16'sd7, 16'sd0, 16'sd3));
        pending_ops.push_back(pack_op(OP_ADD, 16'sd1, 16'sd2, -16'sd1, 16'sd2));
        pending_ops.push_back(pack_op(OP_SUB, 16'sd3, -16'sd5, 16'sd3, -16'sd5));
        pending_ops.push_back(pack_op(OP_MUL, 16'sd0, -16'sd9, 16'sd4, 16'sd6));
        pending_ops.push_back(pack_op(OP_DIV, 16'sd0, 16'sd3, -16'sd2, 16'sd5));
        pending_ops.push_back(pack_op(OP_MUL, 16'sd3, -16'sd4, 16'sd5, 16'sd7));
        pending_ops.push_back(pack_op(OP_DIV, 16'sd3, 16'sd4, -16'sd5, 16'sd7));
        pending_ops.push_back(pack_op(OP_MUL, 16'sd1, 16'h8000, 16'sd1, 16'h8000));
        pending_ops.push_back(pack_op(OP_MUL, 16'h8000, 16'sd1, 16'h8000, 16'sd1));
        pending_ops.push_back(pack_op(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        pending_ops.push_back(pack_op(OP_SUB, 16'h8000, 16'sd1, 16'sd32767, -16'sd1));
        pending_ops.push_back(pack_op(OP_DIV, 16'sd6, 16'sd4, 16'sd9, 16'sd6));
        pending_ops.push_back(pack_op(OP_ADD, -16'sd32767, 16'sd1, -16'sd32767, 16'sd1));

        // random operations
        for (int i = 0; i < RAND_ITEMS; i++)
            pending_ops.push_back(pack_op(opcode_t'($urandom_range(0, 3)),
                                          rand_operand(1'b0), rand_operand(1'b1),
                                          rand_operand(1'b0), rand_operand(1'b1)));

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // drain: all sent, all results back, then let the block settle
        while (pending_ops.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_fracs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/rau_pkg.sv
sv/rau_gcd.sv
sv/rau_div.sv
sv/rational_arith_unit.sv
sv/rau_checker.sv
bench/tb_top.sv
